[rtl/cffa_pkg.sv]
// Shared types and constants for the circular first-fit allocator.
// Used by cffa_ram, cffa_seq and circular_first_fit_allocator; depends on nothing.
package cffa_pkg;

  localparam int ARENA_WORDS = 2048;
  localparam int WORD_BYTES  = 2;

  localparam int ADDR_W   = $clog2(ARENA_WORDS);
  localparam int ENTRY_W  = ADDR_W + 1;
  localparam int NW_W     = ADDR_W + 2;
  localparam int COUNT_W  = 13;
  localparam int DROP_W   = 16;
  localparam int SIZE_W   = 12;
  localparam int BUDGET_W = $clog2(4 * ARENA_WORDS + 17);

  localparam logic [ADDR_W-1:0]   TOP_WORD    = ADDR_W'(ARENA_WORDS - 1);
  localparam logic [COUNT_W-1:0]  FREE_INIT   = COUNT_W'((ARENA_WORDS - 2) * WORD_BYTES);
  localparam logic [COUNT_W-1:0]  FREE_CEIL   = COUNT_W'(ARENA_WORDS * WORD_BYTES);
  localparam logic [BUDGET_W-1:0] STEP_BUDGET = BUDGET_W'(4 * ARENA_WORDS + 16);
  localparam logic [DROP_W-1:0]   DROP_MAX    = '1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_HDR,
    S_A_MRG,
    S_A_SPLIT,
    S_A_MARK,
    S_F_HDR,
    S_DONE
  } state_t;

  // Request from the sequencer to the header memory.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } ram_req_t;

endpackage

[rtl/circular_first_fit_allocator.sv]
// Top level of the circular first-fit allocator.
// Depends on cffa_pkg, cffa_ram and cffa_seq.
//
// A request is taken at a rising edge with start high and busy low: mode 0
// allocates size_bytes rounded up to whole words plus a header word, mode 1
// frees the block whose data area starts at block_addr. Each request gives
// exactly one result, shown for one cycle with done high: status, data_addr,
// and the free byte count, low-water mark and drop count after the request.
// The receiver cannot stall; a result that is not taken in that cycle is gone.
// A free reads the header word before done comes; for block_addr 0 done comes
// without a read. An allocate walks the chain from the search pointer: a busy
// header is one step, an idle header adds a step plus one per merged idle block,
// then a failed walk finishes or the block is split, marked and reported. The
// walk does one read of the header memory per step, so its length grows with
// fragmentation; it is bounded by the step budget of 8208 visits and merges.
// busy is high through the done cycle and the next request can be taken in the
// cycle after done.
// After reset a clearing pass writes all 2048 header words, one per cycle,
// and busy stays high until the pass is over, before the first request.
module circular_first_fit_allocator
  import cffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               mode,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [ADDR_W-1:0]  block_addr,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  data_addr,
  output logic [COUNT_W-1:0] free_bytes,
  output logic [COUNT_W-1:0] low_water_bytes,
  output logic [DROP_W-1:0]  drop_count
);

  ram_req_t req;
  entry_t   rdata;

  // Header memory.
  cffa_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Sequencer and counters.
  cffa_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .mode            (mode),
    .size_bytes      (size_bytes),
    .block_addr      (block_addr),
    .rdata           (rdata),
    .req             (req),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .data_addr       (data_addr),
    .free_bytes      (free_bytes),
    .low_water_bytes (low_water_bytes),
    .drop_count      (drop_count)
  );

  // A failed request never reports a data address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> data_addr == '0)
    else $error("failed request reported a data address");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // The low-water mark never exceeds the free count.
  a_low_water: assert property (@(posedge clk) disable iff (rst)
    low_water_bytes <= free_bytes)
    else $error("low-water mark above free byte count");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

[rtl/cffa_ram.sv]
// Header-word memory of the allocator: one write port, one registered read port.
// Depends on cffa_pkg.
module cffa_ram
  import cffa_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [ARENA_WORDS];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/cffa_seq.sv]
// Sequencer and shared datapath of the allocator: clearing pass, chain walk,
// merge, split, free and the byte counters. Depends on cffa_pkg.
module cffa_seq
  import cffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               mode,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  addr_t              block_addr,
  input  entry_t             rdata,
  output ram_req_t           req,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output addr_t              data_addr,
  output logic [COUNT_W-1:0] free_bytes,
  output logic [COUNT_W-1:0] low_water_bytes,
  output logic [DROP_W-1:0]  drop_count
);

  state_t state, state_next;
  addr_t clr_addr, clr_addr_next;
  addr_t p, p_next;
  addr_t q, q_next;
  entry_t ep, ep_next;
  logic [NW_W-1:0] nw, nw_next;
  logic [BUDGET_W-1:0] budget, budget_next;
  logic wraps, wraps_next;
  addr_t search_ptr, search_ptr_next;
  logic [COUNT_W-1:0] free_count, free_count_next;
  logic [COUNT_W-1:0] low_water, low_water_next;
  logic [DROP_W-1:0] drops, drops_next;
  status_t status_r, status_next;
  addr_t data_addr_r, data_addr_next;

  // Decoded memory word and shared compares.
  addr_t rd_link;
  logic rd_busy;
  addr_t adv_link;
  logic adv_fwd, adv_wrap, adv_go;
  logic budget_out, fit, merge_ok, free_ok;
  logic [NW_W-1:0] p_plus_nw;
  addr_t np;
  logic [NW_W-1:0] nw_calc;
  logic [COUNT_W-1:0] used;
  logic [COUNT_W:0] free_sum;

  assign rd_link    = rdata[ENTRY_W-1:1];
  assign rd_busy    = rdata[0];
  assign adv_link   = (state == S_A_HDR) ? rd_link : q;
  assign adv_fwd    = adv_link > p;
  assign adv_wrap   = (p == TOP_WORD) && (adv_link == '0);
  assign adv_go     = adv_fwd || (adv_wrap && !wraps);
  assign budget_out = budget >= STEP_BUDGET;
  assign p_plus_nw  = NW_W'(p) + nw;
  assign fit        = NW_W'(q) >= p_plus_nw;
  assign np         = p_plus_nw[ADDR_W-1:0];
  assign merge_ok   = (q > p) && (q < TOP_WORD);
  assign free_ok    = rd_link > p;
  assign nw_calc    = NW_W'((NW_W'(size_bytes) + NW_W'(2 * WORD_BYTES - 1)) / WORD_BYTES);
  assign used       = COUNT_W'(nw * WORD_BYTES);
  assign free_sum   = (COUNT_W + 1)'(free_count)
                    + (COUNT_W + 1)'((rd_link - p) * WORD_BYTES);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == TOP_WORD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_ALLOC) state_next = S_A_HDR;
          else if (block_addr == '0) state_next = S_DONE;
          else state_next = S_F_HDR;
        end
      end
      S_A_HDR: begin
        if (budget_out) state_next = S_DONE;
        else if (!rd_busy) state_next = S_A_MRG;
        else if (adv_go) state_next = S_A_HDR;
        else state_next = S_DONE;
      end
      S_A_MRG: begin
        if (rd_busy) begin
          if (fit) state_next = S_A_SPLIT;
          else if (adv_go) state_next = S_A_HDR;
          else state_next = S_DONE;
        end else if (!merge_ok || budget_out) begin
          state_next = S_DONE;
        end
      end
      S_A_SPLIT: state_next = S_A_MARK;
      S_A_MARK:  state_next = S_DONE;
      S_F_HDR:   state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory requests and datapath register updates.
  always_comb begin
    req             = '0;
    clr_addr_next   = clr_addr;
    p_next          = p;
    q_next          = q;
    ep_next         = ep;
    nw_next         = nw;
    budget_next     = budget;
    wraps_next      = wraps;
    search_ptr_next = search_ptr;
    free_count_next = free_count;
    low_water_next  = low_water;
    drops_next      = drops;
    status_next     = status_r;
    data_addr_next  = data_addr_r;
    case (state)
      S_CLEAR: begin
        req.we        = 1'b1;
        req.waddr     = clr_addr;
        if (clr_addr == '0) req.wdata = {TOP_WORD, 1'b0};
        else if (clr_addr == TOP_WORD) req.wdata = {addr_t'(0), 1'b1};
        else req.wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
      end
      S_IDLE: begin
        data_addr_next = '0;
        budget_next    = '0;
        wraps_next     = 1'b0;
        nw_next        = nw_calc;
        if (mode == MODE_ALLOC) begin
          p_next    = search_ptr;
          req.raddr = search_ptr;
        end else begin
          p_next      = block_addr - 1'b1;
          req.raddr   = block_addr - 1'b1;
          status_next = ST_BADFREE;
        end
      end
      S_A_HDR: begin
        if (budget_out) begin
          status_next = ST_CORRUPT;
        end else begin
          budget_next = budget + 1'b1;
          if (!rd_busy) begin
            ep_next   = rdata;
            q_next    = rd_link;
            req.raddr = rd_link;
          end else if (adv_go) begin
            if (!adv_fwd) wraps_next = 1'b1;
            p_next    = adv_link;
            req.raddr = adv_link;
          end else if (!adv_wrap) begin
            status_next = ST_CORRUPT;
          end else begin
            status_next = ST_NOSPACE;
            if (drops != DROP_MAX) drops_next = drops + 1'b1;
          end
        end
      end
      S_A_MRG: begin
        if (rd_busy) begin
          if (!fit) begin
            if (adv_go) begin
              if (!adv_fwd) wraps_next = 1'b1;
              p_next    = adv_link;
              req.raddr = adv_link;
            end else if (!adv_wrap) begin
              status_next = ST_CORRUPT;
            end else begin
              status_next = ST_NOSPACE;
              if (drops != DROP_MAX) drops_next = drops + 1'b1;
            end
          end
        end else if (!merge_ok || budget_out) begin
          status_next = ST_CORRUPT;
        end else begin
          // Absorb the idle successor into the current block.
          budget_next = budget + 1'b1;
          req.we      = 1'b1;
          req.waddr   = p;
          req.wdata   = rdata;
          ep_next     = rdata;
          q_next      = rd_link;
          req.raddr   = rd_link;
        end
      end
      S_A_SPLIT: begin
        if (NW_W'(q) > p_plus_nw) begin
          req.we    = 1'b1;
          req.waddr = np;
          req.wdata = ep;
        end
      end
      S_A_MARK: begin
        req.we          = 1'b1;
        req.waddr       = p;
        req.wdata       = {np, 1'b1};
        search_ptr_next = np;
        free_count_next = (free_count > used) ? free_count - used : '0;
        if (free_count_next < low_water) low_water_next = free_count_next;
        data_addr_next  = p + 1'b1;
        status_next     = ST_OK;
      end
      S_F_HDR: begin
        if (!rd_busy) begin
          status_next = ST_BADFREE;
        end else if (!free_ok) begin
          status_next = ST_CORRUPT;
        end else begin
          req.we          = 1'b1;
          req.waddr       = p;
          req.wdata       = {rd_link, 1'b0};
          free_count_next = (free_sum > (COUNT_W + 1)'(FREE_CEIL))
                          ? FREE_CEIL : free_sum[COUNT_W-1:0];
          status_next     = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      search_ptr <= '0;
      free_count <= FREE_INIT;
      low_water  <= FREE_INIT;
      drops      <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      search_ptr <= search_ptr_next;
      free_count <= free_count_next;
      low_water  <= low_water_next;
      drops      <= drops_next;
    end
  end

  // Working registers of the walk and the result fields.
  always_ff @(posedge clk) begin
    p           <= p_next;
    q           <= q_next;
    ep          <= ep_next;
    nw          <= nw_next;
    budget      <= budget_next;
    wraps       <= wraps_next;
    status_r    <= status_next;
    data_addr_r <= data_addr_next;
  end

  assign busy            = (state != S_IDLE);
  assign done            = (state == S_DONE);
  assign status          = status_r;
  assign data_addr       = data_addr_r;
  assign free_bytes      = free_count;
  assign low_water_bytes = low_water;
  assign drop_count      = drops;

endmodule

[tb/circular_first_fit_allocator_tb.sv]
// Self-checking testbench for the circular first-fit allocator.
// Depends on cffa_pkg and circular_first_fit_allocator; it drives allocate and
// free requests and checks every result against its own model of the header chain.
module circular_first_fit_allocator_tb;
  import cffa_pkg::*;

  localparam int NUM_RANDOM  = 600;
  localparam int CYCLE_LIMIT = 50_000_000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    mode_t             op;
    logic [SIZE_W-1:0] nbytes;
    addr_t             baddr;
  } alloc_req_t;

  typedef struct {
    status_t            st;
    addr_t              daddr;
    logic [COUNT_W-1:0] freeb;
    logic [COUNT_W-1:0] loww;
    logic [DROP_W-1:0]  drops;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic [SIZE_W-1:0] size_bytes = '0;
  addr_t block_addr = '0;
  logic busy, done;
  logic [1:0] status;
  addr_t data_addr;
  logic [COUNT_W-1:0] free_bytes, low_water_bytes;
  logic [DROP_W-1:0] drop_count;

  circular_first_fit_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .mode(mode), .size_bytes(size_bytes), .block_addr(block_addr),
    .status(status), .data_addr(data_addr), .free_bytes(free_bytes),
    .low_water_bytes(low_water_bytes), .drop_count(drop_count)
  );

  always #5 clk = ~clk;

  // Model state of the arena: header words hold (link << 1) | busy.
  int unsigned hdr_mem [ARENA_WORDS];
  int unsigned rover;
  int unsigned free_cnt;
  int unsigned low_mark;
  int unsigned drop_cnt;

  alloc_req_t    pending_reqs[$];
  alloc_result_t expected_results[$];
  int unsigned   live_blocks[$];
  int            n_accepted = 0;
  int            n_checked = 0;
  int            n_errors = 0;
  int            status_seen [4] = '{0, 0, 0, 0};
  int            cycle_count = 0;

  function automatic void reset_arena();
    foreach (hdr_mem[i]) hdr_mem[i] = 0;
    hdr_mem[0] = TOP_WORD << 1;
    hdr_mem[TOP_WORD] = 1;
    rover = 0;
    free_cnt = FREE_INIT;
    low_mark = FREE_INIT;
    drop_cnt = 0;
  endfunction

  // First-fit walk from the rover, merging idle neighbors on the way.
  function automatic status_t model_alloc(input int unsigned nbytes,
                                          output int unsigned addr);
    int unsigned nw, p, q, np, used, steps, wraps;
    nw = (nbytes + 2 * WORD_BYTES - 1) / WORD_BYTES;
    p = rover;
    q = 0;
    steps = 0;
    wraps = 0;
    addr = 0;
    if (p > TOP_WORD) return ST_CORRUPT;
    while (1'b1) begin
      steps++;
      if (steps > STEP_BUDGET) return ST_CORRUPT;
      if ((hdr_mem[p] & 1) == 0) begin
        while (1'b1) begin
          q = hdr_mem[p] >> 1;
          if (q >= ARENA_WORDS) return ST_CORRUPT;
          if (hdr_mem[q] & 1) break;
          if (!(q > p && q < TOP_WORD)) return ST_CORRUPT;
          steps++;
          if (steps > STEP_BUDGET) return ST_CORRUPT;
          hdr_mem[p] = hdr_mem[q];
        end
        if (q >= p + nw) break;
      end
      q = p;
      p = hdr_mem[q] >> 1;
      if (p > q) begin
        if (p > TOP_WORD) return ST_CORRUPT;
      end else if (q != TOP_WORD || p != 0) begin
        return ST_CORRUPT;
      end else begin
        wraps++;
        if (wraps > 1) begin
          if (drop_cnt < DROP_MAX) drop_cnt++;
          return ST_NOSPACE;
        end
      end
    end
    // Split the block and mark the front part busy.
    np = p + nw;
    if (q > np) hdr_mem[np] = hdr_mem[p];
    hdr_mem[p] = (np << 1) | 1;
    rover = np;
    used = nw * WORD_BYTES;
    free_cnt = (free_cnt > used) ? free_cnt - used : 0;
    if (free_cnt < low_mark) low_mark = free_cnt;
    addr = p + 1;
    return ST_OK;
  endfunction

  function automatic status_t model_free(input int unsigned a);
    int unsigned h, l, add;
    if (a == 0 || a > TOP_WORD) return ST_BADFREE;
    h = a - 1;
    if ((hdr_mem[h] & 1) == 0) return ST_BADFREE;
    l = hdr_mem[h] >> 1;
    if (!(l > h && l <= TOP_WORD)) return ST_CORRUPT;
    hdr_mem[h] = l << 1;
    add = (l - h) * WORD_BYTES;
    free_cnt = (free_cnt + add > FREE_CEIL) ? FREE_CEIL : free_cnt + add;
    return ST_OK;
  endfunction

  // Apply one accepted request to the model and queue its expected result.
  function automatic void predict_request(input alloc_req_t r);
    alloc_result_t res;
    int unsigned addr;
    addr = 0;
    if (r.op == MODE_ALLOC) begin
      res.st = model_alloc(32'(r.nbytes), addr);
      if (res.st == ST_OK) live_blocks.push_back(addr);
    end else begin
      res.st = model_free(32'(r.baddr));
      if (res.st == ST_OK) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == 32'(r.baddr)) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    res.daddr = addr_t'(addr);
    res.freeb = COUNT_W'(free_cnt);
    res.loww = COUNT_W'(low_mark);
    res.drops = DROP_W'(drop_cnt);
    expected_results.push_back(res);
  endfunction

  function automatic alloc_req_t make_req(input mode_t op, input int unsigned nbytes,
                                          input int unsigned baddr);
    alloc_req_t r;
    r.op = op;
    r.nbytes = SIZE_W'(nbytes);
    r.baddr = addr_t'(baddr);
    return r;
  endfunction

  // Mostly allocations of small blocks and frees of live ones, plus noise.
  function automatic alloc_req_t random_req();
    int unsigned pick, sz;
    pick = $urandom_range(0, 99);
    if (pick < 60 || (pick < 90 && live_blocks.size() == 0)) begin
      sz = $urandom_range(0, 99);
      if (sz < 85) sz = $urandom_range(0, 40);
      else if (sz < 95) sz = $urandom_range(0, 400);
      else sz = $urandom_range(0, 4095);
      return make_req(MODE_ALLOC, sz, $urandom_range(0, 2047));
    end else if (pick < 90) begin
      return make_req(MODE_FREE, $urandom_range(0, 4095),
                      live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end else begin
      return make_req(mode_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                      $urandom_range(0, 2047));
    end
  endfunction

  // Sender idling: light first, heavy second, none at the end.
  function automatic bit sender_idles();
    if (n_accepted < 250) return $urandom_range(0, 99) < 23;
    if (n_accepted < 450) return $urandom_range(0, 99) < 80;
    return 1'b0;
  endfunction

  // Driver: a request is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(make_req(mode_t'(mode), size_bytes, block_addr));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && !sender_idles()) begin
          alloc_req_t r;
          r = pending_reqs.pop_front();
          start <= 1'b1;
          mode <= r.op;
          size_bytes <= r.nbytes;
          block_addr <= r.baddr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle carries one result for the oldest request.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        n_errors++;
      end else begin
        alloc_result_t e;
        e = expected_results.pop_front();
        n_checked++;
        status_seen[e.st]++;
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          n_errors++;
        end
        if (data_addr !== e.daddr) begin
          $error("data_addr: expected %0d, got %0d", e.daddr, data_addr);
          n_errors++;
        end
        if (free_bytes !== e.freeb) begin
          $error("free_bytes: expected %0d, got %0d", e.freeb, free_bytes);
          n_errors++;
        end
        if (low_water_bytes !== e.loww) begin
          $error("low_water_bytes: expected %0d, got %0d", e.loww, low_water_bytes);
          n_errors++;
        end
        if (drop_count !== e.drops) begin
          $error("drop_count: expected %0d, got %0d", e.drops, drop_count);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int n_made;
    reset_arena();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: extremes, bad frees and a whole-arena allocation.
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 10, 2047));
    pending_reqs.push_back(make_req(MODE_FREE, 4095, 1));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 1));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 0));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 2047));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 3));
    pending_reqs.push_back(make_req(MODE_ALLOC, 4095, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 4093, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 4092, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 2));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 1));
    pending_reqs.push_back(make_req(MODE_ALLOC, 1, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 2, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 3, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 2047, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 2048, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 4095, 0));

    // Random requests are made one at a time so frees see the live blocks.
    n_made = 0;
    while (n_made < NUM_RANDOM) begin
      @(posedge clk);
      if (pending_reqs.size() == 0 && expected_results.size() == 0 && !start) begin
        pending_reqs.push_back(random_req());
        n_made++;
      end
    end

    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked in %0d cycles",
             n_accepted, n_checked, cycle_count);
    $display("results by status: ok %0d, no space %0d, bad free %0d, corrupt %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
